>>> rtl/sqrp_pkg.sv
package sqrp_pkg;

   // default counter width for half-period timing
   localparam int COUNT_WIDTH_DEF = 17;
   // width used for clamping before narrowing to the counter width
   localparam int WIDE_W = 25;

   // command codes
   localparam logic [2:0] MODE_TICK       = 3'd0;
   localparam logic [2:0] MODE_QUAD_OPEN  = 3'd1;
   localparam logic [2:0] MODE_QUAD_CLOSE = 3'd2;
   localparam logic [2:0] MODE_NORM_OPEN  = 3'd3;
   localparam logic [2:0] MODE_NORM_CLOSE = 3'd4;
   localparam logic [2:0] MODE_CALIB      = 3'd5;

   // position status codes
   localparam logic [1:0] STAT_OPENED = 2'd0;
   localparam logic [1:0] STAT_CLOSED = 2'd1;
   localparam logic [1:0] STAT_ERROR  = 2'd2;

   // register indexes
   localparam logic [2:0] REG_QUAD_A      = 3'd0;
   localparam logic [2:0] REG_QUAD_B      = 3'd1;
   localparam logic [2:0] REG_X_START     = 3'd2;
   localparam logic [2:0] REG_X_STEP      = 3'd3;
   localparam logic [2:0] REG_STEP_COUNT  = 3'd4;
   localparam logic [2:0] REG_NORMAL_HALF = 3'd5;
   localparam logic [2:0] REG_CALIB_HALF  = 3'd6;

   // register reset values
   localparam logic [15:0] QUAD_A_RST      = 16'd9600;
   localparam logic [15:0] QUAD_B_RST      = 16'd0;
   localparam logic [15:0] X_START_RST     = 16'hB000;
   localparam logic [14:0] X_STEP_RST      = 15'd154;
   localparam logic [15:0] STEP_COUNT_RST  = 16'd267;
   localparam logic [15:0] NORMAL_HALF_RST = 16'd1000;
   localparam logic [15:0] CALIB_HALF_RST  = 16'd5000;

   typedef struct packed {
      logic [15:0]        quad_a;
      logic [15:0]        quad_b;
      logic signed [15:0] x_start;
      logic [14:0]        x_step;
      logic [15:0]        step_count;
      logic [15:0]        normal_half_period;
      logic [15:0]        calib_half_period;
   } cfg_type;

   // status from the two limit switch levels
   function automatic logic [1:0] switch_status(input logic op, input logic cl);
      logic [1:0] st;
      if (op && !cl) begin
         st = STAT_OPENED;
      end else if (!op && cl) begin
         st = STAT_CLOSED;
      end else begin
         st = STAT_ERROR;
      end
      return st;
   endfunction

   // end test for normal moves and calibration
   function automatic logic end_reached(input logic [2:0] m, input logic op,
                                        input logic cl);
      logic hit;
      if (m == MODE_NORM_OPEN) begin
         hit = op;
      end else if (m == MODE_NORM_CLOSE) begin
         hit = cl;
      end else begin
         hit = (switch_status(op, cl) == STAT_OPENED);
      end
      return hit;
   endfunction

endpackage

>>> rtl/sqrp_ifs.sv
// tick/command word channel
interface sqrp_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] mode;
   logic       open_switch;
   logic       close_switch;

   modport source (output valid, mode, open_switch, close_switch, input ready);
   modport sink   (input valid, mode, open_switch, close_switch, output ready);
endinterface

// output level word channel
interface sqrp_rsp_if;
   logic       valid;
   logic       ready;
   logic       step_pulse;
   logic       direction;
   logic       busy_res;
   logic [1:0] position_status;

   modport source (output valid, step_pulse, direction, busy_res, position_status,
                   input ready);
   modport sink   (input valid, step_pulse, direction, busy_res, position_status,
                   output ready);
endinterface

// register write channel
interface sqrp_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/sqrp_csr.sv
module sqrp_csr (
   input  logic              clock,
   input  logic              reset,
   sqrp_csr_if.sink          csr_chan,
   output sqrp_pkg::cfg_type cfg
);

   sqrp_pkg::cfg_type cfg_ff;

   // writes are always taken
   assign csr_chan.ready = 1'b1;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.quad_a             <= sqrp_pkg::QUAD_A_RST;
         cfg_ff.quad_b             <= sqrp_pkg::QUAD_B_RST;
         cfg_ff.x_start            <= sqrp_pkg::X_START_RST;
         cfg_ff.x_step             <= sqrp_pkg::X_STEP_RST;
         cfg_ff.step_count         <= sqrp_pkg::STEP_COUNT_RST;
         cfg_ff.normal_half_period <= sqrp_pkg::NORMAL_HALF_RST;
         cfg_ff.calib_half_period  <= sqrp_pkg::CALIB_HALF_RST;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            sqrp_pkg::REG_QUAD_A:      cfg_ff.quad_a             <= csr_chan.data;
            sqrp_pkg::REG_QUAD_B:      cfg_ff.quad_b             <= csr_chan.data;
            sqrp_pkg::REG_X_START:     cfg_ff.x_start            <= csr_chan.data;
            sqrp_pkg::REG_X_STEP:      cfg_ff.x_step             <= csr_chan.data[14:0];
            sqrp_pkg::REG_STEP_COUNT:  cfg_ff.step_count         <= csr_chan.data;
            sqrp_pkg::REG_NORMAL_HALF: cfg_ff.normal_half_period <= csr_chan.data;
            sqrp_pkg::REG_CALIB_HALF:  cfg_ff.calib_half_period  <= csr_chan.data;
            default: ;
         endcase
      end
   end

endmodule

>>> rtl/sqrp_mul.sv
module sqrp_mul (
   input  logic        clock,
   input  logic [15:0] op_a,
   input  logic [15:0] op_b,
   output logic [31:0] prod_ff
);

   // shared 16x16 unsigned multiplier, product registered
   always_ff @(posedge clock) begin
      prod_ff <= 32'(op_a) * 32'(op_b);
   end

endmodule

>>> rtl/stepper_quadratic_ramp_pulser.sv
// Step/direction pulse generator with a quadratic speed ramp.
// req_chan carries one word per microsecond tick: a command mode and the two
// limit switch levels. Every accepted req word yields exactly one rsp word on
// rsp_chan with the step and direction levels, a busy flag and the latched
// position status, all as they stand after that tick. csr_chan writes the
// seven ramp/period registers; it is always ready. The user must use it
// only while idle; the block itself does not enforce this. A req word goes
// from EXEC to OUT, and OUT registers its rsp word. Ticks that load a new
// ramp half period (a quadratic move starting with a nonzero step count, or
// a ramp step ending with more steps to go) also pass SQ, LO, HI and SUM;
// they recompute a*x^2+b on the one shared 16x16 multiplier in three passes
// (x*x, then a times the low and high halves of x^2). req_ready is high only
// in the idle state of the sequencer, so a new req word is taken only once
// the last one is through. A stalled receiver holds the rsp word in its
// output register; the next req word is still taken and worked, and its
// result waits until the register frees up.
// Reset (synchronous) restores register defaults, stops any move, drives
// step low and sets the position status to error.
module stepper_quadratic_ramp_pulser #(
   parameter int COUNT_WIDTH = sqrp_pkg::COUNT_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   sqrp_req_if.sink    req_chan,
   sqrp_rsp_if.source  rsp_chan,
   sqrp_csr_if.sink    csr_chan
);

   localparam int WW = sqrp_pkg::WIDE_W;
   localparam logic [WW-1:0] CNT_MAX_W = {{(WW - COUNT_WIDTH){1'b0}}, {COUNT_WIDTH{1'b1}}};

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_SQ   = 3'd2;
   localparam logic [2:0] S_LO   = 3'd3;
   localparam logic [2:0] S_HI   = 3'd4;
   localparam logic [2:0] S_SUM  = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;

   // saturate to the counter range, zero becomes one
   function automatic logic [COUNT_WIDTH-1:0] clamp_period(input logic [WW-1:0] v);
      logic [COUNT_WIDTH-1:0] r;
      if (v > CNT_MAX_W) begin
         r = CNT_MAX_W[COUNT_WIDTH-1:0];
      end else if (v == '0) begin
         r = {{(COUNT_WIDTH - 1){1'b0}}, 1'b1};
      end else begin
         r = v[COUNT_WIDTH-1:0];
      end
      return r;
   endfunction

   sqrp_pkg::cfg_type cfg;

   logic [2:0]             state_ff, state_in;
   logic [2:0]             mode_ff, mode_in;
   logic                   op_ff, op_in;
   logic                   cl_ff, cl_in;
   logic [2:0]             active_ff, active_in;
   logic [COUNT_WIDTH-1:0] hc_ff, hc_in;
   logic [COUNT_WIDTH-1:0] hp_ff, hp_in;
   logic [15:0]            steps_ff, steps_in;
   logic signed [15:0]     x_ff, x_in;
   logic                   pulse_ff, pulse_in;
   logic                   dir_ff, dir_in;
   logic [1:0]             status_ff, status_in;
   logic [14:0]            sq_hi_ff, sq_hi_in;
   logic [31:0]            lo_ff, lo_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_pulse_ff, rsp_pulse_in;
   logic                   rsp_dir_ff, rsp_dir_in;
   logic                   rsp_busy_ff, rsp_busy_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;

   logic [15:0]            mul_a, mul_b;
   logic [31:0]            prod;
   logic [15:0]            abs_x;
   logic [COUNT_WIDTH-1:0] hc_inc;
   logic                   period_end;
   logic [15:0]            steps_dec;
   logic [16:0]            x_sum;
   logic signed [15:0]     x_next;
   logic [47:0]            acc;
   logic [18:0]            curve_sum;
   logic [15:0]            fixed_half;
   logic                   quad_cmd;
   logic                   norm_cmd;
   logic                   quad_active;

   sqrp_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   sqrp_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod)
   );

   // datapath helpers
   assign abs_x      = x_ff[15] ? (~x_ff + 16'd1) : x_ff;
   assign hc_inc     = hc_ff + {{(COUNT_WIDTH - 1){1'b0}}, 1'b1};
   assign period_end = (hc_inc >= hp_ff);
   assign steps_dec  = steps_ff - 16'd1;
   assign x_sum      = {x_ff[15], x_ff} + {2'b00, cfg.x_step};
   assign x_next     = (!x_sum[16] && x_sum[15]) ? 16'sh7FFF : x_sum[15:0];
   assign acc        = {prod, 16'h0000} + {16'h0000, lo_ff};
   assign curve_sum  = {1'b0, acc[47:30]} + {3'b000, cfg.quad_b};
   assign fixed_half = (mode_ff == sqrp_pkg::MODE_CALIB) ? cfg.calib_half_period
                                                         : cfg.normal_half_period;
   assign quad_cmd   = (mode_ff == sqrp_pkg::MODE_QUAD_OPEN) ||
                       (mode_ff == sqrp_pkg::MODE_QUAD_CLOSE);
   assign norm_cmd   = (mode_ff == sqrp_pkg::MODE_NORM_OPEN) ||
                       (mode_ff == sqrp_pkg::MODE_NORM_CLOSE) ||
                       (mode_ff == sqrp_pkg::MODE_CALIB);
   assign quad_active = (active_ff == sqrp_pkg::MODE_QUAD_OPEN) ||
                        (active_ff == sqrp_pkg::MODE_QUAD_CLOSE);

   // multiplier operand select
   always_comb begin
      mul_a = cfg.quad_a;
      mul_b = 16'd0;
      unique case (state_ff)
         S_SQ: begin
            mul_a = abs_x;
            mul_b = abs_x;
         end
         S_LO:    mul_b = prod[15:0];
         S_HI:    mul_b = {1'b0, sq_hi_ff};
         default: ;
      endcase
   end

   assign req_chan.ready         = (state_ff == S_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.step_pulse    = rsp_pulse_ff;
   assign rsp_chan.direction     = rsp_dir_ff;
   assign rsp_chan.busy_res      = rsp_busy_ff;
   assign rsp_chan.position_status = rsp_status_ff;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      op_in         = op_ff;
      cl_in         = cl_ff;
      active_in     = active_ff;
      hc_in         = hc_ff;
      hp_in         = hp_ff;
      steps_in      = steps_ff;
      x_in          = x_ff;
      pulse_in      = pulse_ff;
      dir_in        = dir_ff;
      status_in     = status_ff;
      sq_hi_in      = sq_hi_ff;
      lo_in         = lo_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_pulse_in  = rsp_pulse_ff;
      rsp_dir_in    = rsp_dir_ff;
      rsp_busy_in   = rsp_busy_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               mode_in  = req_chan.mode;
               op_in    = req_chan.open_switch;
               cl_in    = req_chan.close_switch;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            state_in = S_OUT;
            if (active_ff == sqrp_pkg::MODE_TICK) begin
               // idle: look at the command
               if (quad_cmd) begin
                  dir_in   = (mode_ff == sqrp_pkg::MODE_QUAD_CLOSE);
                  steps_in = cfg.step_count;
                  x_in     = cfg.x_start;
                  if (cfg.step_count == 16'd0) begin
                     active_in = sqrp_pkg::MODE_TICK;
                     pulse_in  = 1'b0;
                     hc_in     = '0;
                     status_in = sqrp_pkg::switch_status(op_ff, cl_ff);
                  end else begin
                     active_in = mode_ff;
                     hc_in     = '0;
                     pulse_in  = 1'b1;
                     state_in  = S_SQ;
                  end
               end else if (norm_cmd) begin
                  dir_in = (mode_ff == sqrp_pkg::MODE_NORM_CLOSE);
                  if (sqrp_pkg::end_reached(mode_ff, op_ff, cl_ff)) begin
                     active_in = sqrp_pkg::MODE_TICK;
                     pulse_in  = 1'b0;
                     hc_in     = '0;
                     status_in = sqrp_pkg::switch_status(op_ff, cl_ff);
                  end else begin
                     active_in = mode_ff;
                     hp_in     = clamp_period({{(WW - 16){1'b0}}, fixed_half});
                     hc_in     = '0;
                     pulse_in  = 1'b1;
                  end
               end
            end else if (!period_end) begin
               hc_in = hc_inc;
            end else begin
               // half period done
               hc_in = '0;
               if (pulse_ff) begin
                  pulse_in = 1'b0;
               end else if (quad_active) begin
                  steps_in = steps_dec;
                  x_in     = x_next;
                  if (steps_dec == 16'd0) begin
                     active_in = sqrp_pkg::MODE_TICK;
                     pulse_in  = 1'b0;
                     status_in = sqrp_pkg::switch_status(op_ff, cl_ff);
                  end else begin
                     pulse_in = 1'b1;
                     state_in = S_SQ;
                  end
               end else if (sqrp_pkg::end_reached(active_ff, op_ff, cl_ff)) begin
                  active_in = sqrp_pkg::MODE_TICK;
                  pulse_in  = 1'b0;
                  status_in = sqrp_pkg::switch_status(op_ff, cl_ff);
               end else begin
                  pulse_in = 1'b1;
               end
            end
         end

         // x*x issued this cycle
         S_SQ: state_in = S_LO;

         // x^2 ready: keep high half, issue a*low
         S_LO: begin
            sq_hi_in = prod[30:16];
            state_in = S_HI;
         end

         // a*low ready: keep it, issue a*high
         S_HI: begin
            lo_in    = prod;
            state_in = S_SUM;
         end

         // combine, add offset, clamp
         S_SUM: begin
            hp_in    = clamp_period({{(WW - 19){1'b0}}, curve_sum});
            state_in = S_OUT;
         end

         S_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_pulse_in  = pulse_ff;
               rsp_dir_in    = dir_ff;
               rsp_busy_in   = (active_ff != sqrp_pkg::MODE_TICK);
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // control and move state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= sqrp_pkg::MODE_TICK;
         hc_ff        <= '0;
         hp_ff        <= '0;
         steps_ff     <= '0;
         x_ff         <= '0;
         pulse_ff     <= 1'b0;
         dir_ff       <= 1'b0;
         status_ff    <= sqrp_pkg::STAT_ERROR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         hc_ff        <= hc_in;
         hp_ff        <= hp_in;
         steps_ff     <= steps_in;
         x_ff         <= x_in;
         pulse_ff     <= pulse_in;
         dir_ff       <= dir_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      op_ff         <= op_in;
      cl_ff         <= cl_in;
      sq_hi_ff      <= sq_hi_in;
      lo_ff         <= lo_in;
      rsp_pulse_ff  <= rsp_pulse_in;
      rsp_dir_ff    <= rsp_dir_in;
      rsp_busy_ff   <= rsp_busy_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

>>> rtl/sqrp_check.sv
module sqrp_check (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       step_pulse,
   input logic       direction,
   input logic       busy_res,
   input logic [1:0] position_status
);

   // one word in flight: ready drops right after a word is taken
   a_req_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req ready stayed high after a word was taken");

   // no step level outside a move
   a_idle_no_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !busy_res |-> !step_pulse)
      else $error("step pulse high while not busy");

   // status is a defined code
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> position_status <= sqrp_pkg::STAT_ERROR)
      else $error("undefined position status");

   // stalled rsp word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({step_pulse, direction, busy_res, position_status}))
      else $error("rsp word changed while stalled");

endmodule

bind stepper_quadratic_ramp_pulser sqrp_check u_sqrp_check (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .step_pulse      (rsp_chan.step_pulse),
   .direction       (rsp_chan.direction),
   .busy_res        (rsp_chan.busy_res),
   .position_status (rsp_chan.position_status)
);
